[rtl/tcpsg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsg_pkg: shared types and constants for the square-wave tone generator
// Holds channel count, field widths, divider sizing and the sequencer states.
// ----------------------------------------------------------------------------
package tcpsg_pkg;

    // channel count and index width (at least one bit)
    localparam int CHANNELS   = 3;
    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // field widths
    localparam int PERIOD_W   = 6;
    localparam int COUNT_W    = 15;
    localparam int STEP_W     = 8;
    localparam int IDX_W      = 2;
    localparam int DATA_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = SAMPLE_W + 1;

    localparam int STEP_RESET   = 97;
    localparam int PERIOD_SHIFT = 8;
    localparam int FULL_LEVEL   = 8192;

    // divider: quotient of (mag * 2^FRAC_SHIFT) / step, mag <= step
    localparam int FRAC_SHIFT = 13;
    localparam int MAG_W      = 8;
    localparam int DVD_W      = MAG_W + FRAC_SHIFT;
    localparam int QUO_W      = FRAC_SHIFT + 1;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    // input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAN,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

[rtl/tcpsg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsg_div: serial restoring divider for the flip smoothing value
// Computes floor(mag * 2^13 / divisor), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcpsg_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [tcpsg_pkg::MAG_W-1:0]      mag,
    input  logic [tcpsg_pkg::STEP_W-1:0]     divisor,
    output logic [tcpsg_pkg::QUO_W-1:0]      quotient,
    output tcpsg_pkg::div_stat_t             stat
);

    logic [tcpsg_pkg::DVD_W-1:0]  dvd_reg,  dvd_next;
    logic [tcpsg_pkg::STEP_W-1:0] rem_reg,  rem_next;
    logic [tcpsg_pkg::STEP_W-1:0] dsr_reg,  dsr_next;
    logic [tcpsg_pkg::QUO_W-1:0]  quo_reg,  quo_next;
    logic [tcpsg_pkg::DCNT_W-1:0] cnt_reg,  cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [tcpsg_pkg::STEP_W:0]   trial;

    // one shift-subtract step per cycle
    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[tcpsg_pkg::DVD_W-1]};
        if (start) begin
            dvd_next  = {mag, {tcpsg_pkg::FRAC_SHIFT{1'b0}}};
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = '0;
            cnt_next  = tcpsg_pkg::DCNT_W'(tcpsg_pkg::DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the trial fits
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = tcpsg_pkg::STEP_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[tcpsg_pkg::QUO_W-2:0], 1'b1};
            end else begin
                rem_next = trial[tcpsg_pkg::STEP_W-1:0];
                quo_next = {quo_reg[tcpsg_pkg::QUO_W-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[tcpsg_pkg::DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - tcpsg_pkg::DCNT_W'(1);
            if (cnt_reg == tcpsg_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/three_channel_square_psg_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_square_psg_unit: three-channel square-wave tone generator
// Period writes and sample ticks in, one mixed signed sample out per tick.
// ----------------------------------------------------------------------------
// A period write is taken in ST_IDLE. A tick is handled by a sequencer that
// visits the channels one at a time: a channel with a zero period or without
// a level flip is finished in ST_CHAN, and a channel that flips waits in ST_DIV
// for the shared serial divider (21 quotient steps plus start and hand-back).
// A finished tick is held in ST_DONE while the previous sample still waits in
// the output register. The block takes no word while a tick is in work; a
// finished sample waits in the output register and the next word may be
// accepted meanwhile.
// ----------------------------------------------------------------------------
module three_channel_square_psg_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: step_per_sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] channel_index, [9:2] write_data, rest zero
    input  logic        s_tuser,   // [0] op
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] sample (signed)
);

    localparam int CHN = tcpsg_pkg::CHANNELS;
    localparam int CW  = tcpsg_pkg::CH_W;
    localparam int AW  = tcpsg_pkg::ACC_W;

    tcpsg_pkg::state_t state_reg, state_next;

    logic [tcpsg_pkg::STEP_W-1:0]   step_reg,   step_next;
    logic [tcpsg_pkg::PERIOD_W-1:0] period_reg [CHN];
    logic [tcpsg_pkg::PERIOD_W-1:0] period_next[CHN];
    logic [tcpsg_pkg::COUNT_W-1:0]  count_reg  [CHN];
    logic [tcpsg_pkg::COUNT_W-1:0]  count_next [CHN];
    logic                           level_reg  [CHN];
    logic                           level_next [CHN];

    logic [CW-1:0]           ch_reg,   ch_next;
    logic signed [AW-1:0]    acc_reg,  acc_next;
    logic                    neg_reg,  neg_next;
    logic                    oval_reg, oval_next;
    logic [tcpsg_pkg::SAMPLE_W-1:0] odata_reg, odata_next;

    // unpacked input fields
    logic [tcpsg_pkg::IDX_W-1:0]  in_idx;
    logic [tcpsg_pkg::DATA_W-1:0] in_data;
    logic                         in_op;
    logic                         in_fire;

    // channel step datapath
    logic [tcpsg_pkg::COUNT_W-1:0]  prev_count;
    logic [tcpsg_pkg::COUNT_W:0]    diff;
    logic [tcpsg_pkg::COUNT_W:0]    reload;
    logic                           under;
    logic [tcpsg_pkg::STEP_W:0]     twice;
    logic                           num_neg;
    logic [tcpsg_pkg::STEP_W:0]     mag_full;
    logic                           last_ch;
    logic signed [AW-1:0]           full_term;
    logic signed [AW-1:0]           div_term;
    logic [tcpsg_pkg::SAMPLE_W-1:0] sat_sample;

    // divider hookup
    logic                           div_start;
    logic [tcpsg_pkg::QUO_W-1:0]    div_quo;
    tcpsg_pkg::div_stat_t           div_stat;

    assign in_idx  = s_tdata[tcpsg_pkg::IDX_W-1:0];
    assign in_data = s_tdata[tcpsg_pkg::IDX_W +: tcpsg_pkg::DATA_W];
    assign in_op   = s_tuser;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == tcpsg_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;

    // counter step for the channel in hand
    assign prev_count = count_reg[ch_reg];
    assign diff     = {1'b0, prev_count} - (tcpsg_pkg::COUNT_W + 1)'(step_reg);
    assign under    = diff[tcpsg_pkg::COUNT_W];
    assign reload   = diff + (tcpsg_pkg::COUNT_W + 1)'({period_reg[ch_reg],
                                 {tcpsg_pkg::PERIOD_SHIFT{1'b0}}});
    // under a flip the old count is below the step, so it fits in eight bits
    assign twice    = {prev_count[tcpsg_pkg::STEP_W-1:0], 1'b0};
    assign num_neg  = twice < {1'b0, step_reg};
    assign mag_full = num_neg ? ({1'b0, step_reg} - twice) : (twice - {1'b0, step_reg});
    assign last_ch  = (ch_reg == CW'(CHN - 1));

    // contributions: sign follows the level before the tick
    assign full_term = level_reg[ch_reg] ? AW'(tcpsg_pkg::FULL_LEVEL)
                                         : -AW'(tcpsg_pkg::FULL_LEVEL);
    assign div_term  = (neg_reg ^ ~level_reg[ch_reg]) ? -AW'(div_quo) : AW'(div_quo);

    // clamp the sum to the sample range
    always_comb begin
        if (acc_reg[AW-1] != acc_reg[AW-2]) begin
            sat_sample = acc_reg[AW-1] ? {1'b1, {(tcpsg_pkg::SAMPLE_W-1){1'b0}}}
                                       : {1'b0, {(tcpsg_pkg::SAMPLE_W-1){1'b1}}};
        end else begin
            sat_sample = acc_reg[tcpsg_pkg::SAMPLE_W-1:0];
        end
    end

    // sequencer: next state and datapath updates
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        period_next = period_reg;
        count_next  = count_reg;
        level_next  = level_reg;
        ch_next     = ch_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        oval_next   = oval_reg;
        odata_next  = odata_reg;
        div_start   = 1'b0;

        if (m_tready) begin
            oval_next = 1'b0;
        end
        if (cfg_valid) begin
            step_next = cfg_data;
        end

        unique case (state_reg)
            tcpsg_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (in_op == tcpsg_pkg::OP_WRITE) begin
                        if ({30'd0, in_idx} < 32'(CHN)) begin
                            period_next[in_idx[CW-1:0]] =
                                ~in_data[tcpsg_pkg::PERIOD_W-1:0];
                        end
                    end else begin
                        ch_next    = '0;
                        acc_next   = '0;
                        state_next = tcpsg_pkg::ST_CHAN;
                    end
                end
            end
            tcpsg_pkg::ST_CHAN: begin
                if (period_reg[ch_reg] == '0) begin
                    // silent channel
                    if (last_ch) begin
                        state_next = tcpsg_pkg::ST_DONE;
                    end else begin
                        ch_next = ch_reg + CW'(1);
                    end
                end else if (under) begin
                    // flip: reload, toggle, smoothing value from the divider
                    count_next[ch_reg] = reload[tcpsg_pkg::COUNT_W-1:0];
                    level_next[ch_reg] = ~level_reg[ch_reg];
                    neg_next           = num_neg;
                    div_start          = 1'b1;
                    state_next         = tcpsg_pkg::ST_DIV;
                end else begin
                    count_next[ch_reg] = diff[tcpsg_pkg::COUNT_W-1:0];
                    acc_next           = acc_reg + full_term;
                    if (last_ch) begin
                        state_next = tcpsg_pkg::ST_DONE;
                    end else begin
                        ch_next = ch_reg + CW'(1);
                    end
                end
            end
            tcpsg_pkg::ST_DIV: begin
                // level already toggled, so the old level is its inverse
                if (div_stat.done) begin
                    acc_next = acc_reg - div_term;
                    if (last_ch) begin
                        state_next = tcpsg_pkg::ST_DONE;
                    end else begin
                        ch_next    = ch_reg + CW'(1);
                        state_next = tcpsg_pkg::ST_CHAN;
                    end
                end
            end
            tcpsg_pkg::ST_DONE: begin
                if (!oval_reg || m_tready) begin
                    oval_next  = 1'b1;
                    odata_next = sat_sample;
                    state_next = tcpsg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcpsg_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcpsg_pkg::ST_IDLE;
            step_reg  <= tcpsg_pkg::STEP_W'(tcpsg_pkg::STEP_RESET);
            oval_reg  <= 1'b0;
            ch_reg    <= '0;
            for (int i = 0; i < CHN; i++) begin
                period_reg[i] <= '0;
                count_reg[i]  <= '0;
                level_reg[i]  <= 1'b0;
            end
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            oval_reg   <= oval_next;
            ch_reg     <= ch_next;
            period_reg <= period_next;
            count_reg  <= count_next;
            level_reg  <= level_next;
        end
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        odata_reg <= odata_next;
    end

    // shared serial divider
    tcpsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .mag      (mag_full[tcpsg_pkg::MAG_W-1:0]),
        .divisor  (step_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign m_tvalid = oval_reg;
    assign m_tdata  = odata_reg;

endmodule

[tb/sv/tb_three_channel_square_psg_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_channel_square_psg_unit: self-checking bench for the tone generator
// Period writes and sample ticks go in over the input stream. A local tone
// model predicts every mixed sample. The output stream is checked word by word
// against it under random idling on both sides, one long receiver stall and
// several step settings.
// ----------------------------------------------------------------------------
module tb_three_channel_square_psg_unit;
    import tcpsg_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 100;   // longer than the longest tick
    localparam int WORDS_PER_SET = 225;
    localparam int HOLD_AT       = 300;   // input words taken before the long stall
    localparam int HOLD_CYCLES   = 600;
    localparam int REPORT_MAX    = 10;

    // one input word
    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] idx;
        logic [DATA_W-1:0] data;
    } psg_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [1:0] channel_index, [9:2] write_data, rest zero
    logic        s_tuser   = 1'b0; // [0] op
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [15:0] sample (signed)

    three_channel_square_psg_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock, 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // tone model state
    logic [STEP_W-1:0]   step_q = STEP_RESET[STEP_W-1:0];
    logic [PERIOD_W-1:0] period_q [CHANNELS];
    logic [COUNT_W-1:0]  count_q  [CHANNELS];
    logic                level_q  [CHANNELS];

    psg_word_t   tone_words_q [$];
    logic [15:0] expected_samples [$];
    int          mismatches = 0;
    logic [31:0] words_taken = '0;
    logic [31:0] hold_left = '0;
    logic        hold_done = 1'b0;
    int          cycles = 0;

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            period_q[c] = '0;
            count_q[c]  = '0;
            level_q[c]  = 1'b0;
        end
    end

    // advance every tone channel by one sample and mix
    function automatic logic [15:0] advance_tones();
        int acc;
        int prev_count;
        int now;
        int amount;
        int step;
        bit was_high;
        acc  = 0;
        step = int'(step_q);
        for (int c = 0; c < CHANNELS; c++) begin
            if (period_q[c] == '0) continue;   // silent channel
            prev_count = int'(count_q[c]);
            was_high   = level_q[c];
            amount     = FULL_LEVEL;
            now        = prev_count - step;
            if (now < 0) begin
                now += int'(period_q[c]) << PERIOD_SHIFT;
                level_q[c] = !was_high;
                if (step != 0)
                    amount = (FULL_LEVEL * (2 * prev_count - step)) / step;
            end
            count_q[c] = now[COUNT_W-1:0];
            acc += was_high ? amount : -amount;
        end
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return acc[15:0];
    endfunction

    // apply one accepted input word to the model
    function automatic void take_word(input psg_word_t w);
        if (w.op == OP_TICK)
            expected_samples.push_back(advance_tones());
        else if (int'(w.idx) < CHANNELS)
            period_q[w.idx] = 6'h3f - w.data[PERIOD_W-1:0];
    endfunction

    function automatic void note_mismatch(input string what, input logic [15:0] exp_v,
                                          input logic [15:0] got_v);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch (%s): expected %0d, got %0d", what,
                     $signed(exp_v), $signed(got_v));
    endfunction

    // idle gap: mostly short, a few long, with runs of no idling
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic psg_word_t mk_word(input logic op, input logic [1:0] idx,
                                          input logic [7:0] data);
        psg_word_t w;
        w.op   = op;
        w.idx  = idx;
        w.data = data;
        return w;
    endfunction

    // random word: mostly ticks, writes leaning toward short and silent periods
    function automatic psg_word_t rand_word();
        psg_word_t w;
        int r;
        int sel;
        w.data = 8'($urandom_range(0, 255));
        w.idx  = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 68) begin
            w.op = OP_TICK;
        end else begin
            w.op = OP_WRITE;
            sel = $urandom_range(0, 9);
            if (sel < 3)
                w.data[5:0] = 6'd63 - 6'($urandom_range(1, 4));
            else if (sel == 3)
                w.data[5:0] = 6'h3f;
        end
        return w;
    endfunction

    // input driver
    psg_word_t drv_word = '0;
    int        tx_gap = 0;
    int        tx_calm = 0;
    always @(posedge aclk) begin
        bit drive_now;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            s_tdata     <= '0;
            s_tuser     <= 1'b0;
            words_taken <= '0;
        end else begin
            drive_now = s_tvalid;
            if (s_tvalid && s_tready) begin
                take_word(drv_word);
                words_taken <= words_taken + 1;
                drive_now = 1'b0;
            end
            if (!drive_now) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (tone_words_q.size() != 0) begin
                    drv_word  = tone_words_q.pop_front();
                    drive_now = 1'b1;
                    tx_gap    = pick_gap(tx_calm);
                end
            end
            s_tvalid <= drive_now;
            s_tdata  <= {6'b0, drv_word.data, drv_word.idx};
            s_tuser  <= drv_word.op;
        end
    end

    // long receiver stall, once, while the sender keeps offering
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= '0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // output monitor and checker
    int rx_gap = 0;
    int rx_calm = 0;
    always @(posedge aclk) begin
        logic [15:0] exp_v;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    note_mismatch("unexpected word", '0, m_tdata);
                end else begin
                    exp_v = expected_samples.pop_front();
                    if (m_tdata !== exp_v)
                        note_mismatch("sample", exp_v, m_tdata);
                end
                rx_gap = pick_gap(rx_calm);
            end
            if (rx_gap > 0) rx_gap--;
            m_tready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // wait until the block is idle: nothing pending, nothing expected
    task automatic settle();
        while (tone_words_q.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_step(input logic [7:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        step_q = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_set(input logic [7:0] step);
        settle();
        write_step(step);
        repeat (WORDS_PER_SET) tone_words_q.push_back(rand_word());
    endtask

    // stimulus sequence
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset step, all channels silent at first
        tone_words_q.push_back(mk_word(OP_TICK, 2'd0, 8'h00));
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd0, 8'h00));   // period 63
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd1, 8'hff));   // period 0, silent
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd2, 8'h3e));   // period 1
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd3, 8'h00));   // no such channel
        repeat (4) tone_words_q.push_back(mk_word(OP_TICK, 2'd3, 8'hff));
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd1, 8'hc0));   // period 63
        repeat (3) tone_words_q.push_back(mk_word(OP_TICK, 2'd0, 8'h00));
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd0, 8'h3e));   // shrink while counting
        repeat (3) tone_words_q.push_back(mk_word(OP_TICK, 2'd1, 8'h55));
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd3, 8'haa));
        tone_words_q.push_back(mk_word(OP_TICK, 2'd2, 8'haa));
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd1, 8'h55));
        tone_words_q.push_back(mk_word(OP_TICK, 2'd0, 8'h00));
        tone_words_q.push_back(mk_word(OP_WRITE, 2'd2, 8'h7f));   // silence channel 2
        repeat (2) tone_words_q.push_back(mk_word(OP_TICK, 2'd0, 8'h00));

        // random sets over the step range, extremes included
        random_set(8'd1);
        random_set(8'd255);
        random_set(8'd0);
        random_set(8'($urandom_range(2, 254)));
        random_set(8'd97);

        settle();
        while (expected_samples.size() != 0)
            note_mismatch("missing word", expected_samples.pop_front(), '0);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/tcpsg_pkg.sv
rtl/tcpsg_div.sv
rtl/three_channel_square_psg_unit.sv
tb/sv/tb_three_channel_square_psg_unit.sv
